### hdl/wprt_pkg.sv
// Shared codes, default sizes and controller/datapath signal groups for the pick table.
package wprt_pkg;

  // default sizing of the table
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned WEIGHT_BITS_DEF = 16;
  localparam int unsigned DATA_BITS_DEF   = 32;

  // fixed field widths on the ports
  localparam int unsigned OP_W      = 2;
  localparam int unsigned NDATA_W   = 32;
  localparam int unsigned NWEIGHT_W = 16;
  localparam int unsigned INDEX_W   = 22;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned LEFT_W    = 22;
  localparam int unsigned HELD_W    = 7;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_PICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic                load;        // latch the accepted word
    logic                append;      // write tail entry, bump count and total
    logic                clear;       // empty the table
    logic                rd_first;    // start scan at the head
    logic                advance;     // step pointer, read next entry
    logic                accum;       // add current weight to running sum
    logic                take;        // record picked entry, lower total
    logic                move;        // write current entry one place down
    logic                drop;        // count one entry fewer
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                emit;        // load the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            hit;       // running sum reaches the index at this entry
    logic            more;      // an entry exists past the pointer
    logic            out_busy;  // output register still holds an untaken word
  } stat_t;

endpackage

### hdl/wprt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wprt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/wprt_ctrl.sv
// Controller state machine: sequences append, pick scan, compaction and result.
module wprt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  wprt_pkg::stat_t st,
  output wprt_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        case (st.op)
          wprt_pkg::OP_APPEND: begin
            if (st.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = wprt_pkg::ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          wprt_pkg::OP_PICK: begin
            if (st.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = wprt_pkg::ST_NOT_FOUND;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          wprt_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd.take = 1'b1;
          if (st.more) begin
            cmd.advance = 1'b1;
            state_nxt   = S_SHIFT;
          end else begin
            cmd.drop  = 1'b1;
            state_nxt = S_FINISH;
          end
        end else if (st.more) begin
          cmd.advance = 1'b1;
          cmd.accum   = 1'b1;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = wprt_pkg::ST_NOT_FOUND;
          state_nxt      = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.move = 1'b1;
        if (st.more) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.drop  = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/wprt_dp.sv
// Datapath: entry RAM, count, total, running sum, scan pointer and output register.
module wprt_dp #(
  parameter int unsigned TABLE_DEPTH = wprt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WEIGHT_BITS = wprt_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned DATA_BITS   = wprt_pkg::DATA_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [wprt_pkg::OP_W-1:0]         in_op,
  input  logic [wprt_pkg::NDATA_W-1:0]      in_data,
  input  logic [wprt_pkg::NWEIGHT_W-1:0]    in_weight,
  input  logic [wprt_pkg::INDEX_W-1:0]      in_index,
  input  wprt_pkg::cmd_t                    cmd,
  output wprt_pkg::stat_t                   st,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wprt_pkg::STATUS_W-1:0]     out_status,
  output logic [wprt_pkg::PDATA_W-1:0]      out_picked,
  output logic [wprt_pkg::LEFT_W-1:0]       out_left,
  output logic [wprt_pkg::HELD_W-1:0]       out_held
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TW   = WEIGHT_BITS + CW;
  localparam int unsigned EW   = DATA_BITS + WEIGHT_BITS;
  localparam int unsigned CMPW = (TW > wprt_pkg::INDEX_W) ? TW : wprt_pkg::INDEX_W;
  localparam int unsigned LXW  = (TW > wprt_pkg::LEFT_W) ? TW : wprt_pkg::LEFT_W;
  localparam int unsigned DX   = (DATA_BITS > wprt_pkg::NDATA_W) ? DATA_BITS : wprt_pkg::NDATA_W;
  localparam int unsigned WX   = (WEIGHT_BITS > wprt_pkg::NWEIGHT_W) ?
                                 WEIGHT_BITS : wprt_pkg::NWEIGHT_W;
  localparam int unsigned HX   = (CW > wprt_pkg::HELD_W) ? CW : wprt_pkg::HELD_W;

  // latched word
  logic [wprt_pkg::OP_W-1:0]     op_r;
  logic [DATA_BITS-1:0]          data_r;
  logic [WEIGHT_BITS-1:0]        weight_r;
  logic [wprt_pkg::INDEX_W-1:0]  target_r;

  // table state
  logic [CW-1:0] count_r;
  logic [TW-1:0] total_r;
  logic [AW-1:0] ptr_r;
  logic [TW-1:0] run_r;

  // result under construction
  logic [wprt_pkg::STATUS_W-1:0] status_r;
  logic [wprt_pkg::PDATA_W-1:0]  picked_r;

  // output register
  logic                          out_valid_r;
  logic [wprt_pkg::STATUS_W-1:0] out_status_r;
  logic [wprt_pkg::PDATA_W-1:0]  out_picked_r;
  logic [wprt_pkg::LEFT_W-1:0]   out_left_r;
  logic [wprt_pkg::HELD_W-1:0]   out_held_r;

  // RAM ports
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [EW-1:0] ram_wr_data, ram_rd_data;

  logic [WEIGHT_BITS-1:0] cur_weight;
  logic [DATA_BITS-1:0]   cur_data;
  logic [CW-1:0]          ptr_inc;
  logic [TW-1:0]          run_sum;
  logic [CMPW-1:0]        sum_ext, tgt_ext;
  logic [DX-1:0]          in_data_ext, cur_data_ext;
  logic [WX-1:0]          in_weight_ext;
  logic [LXW-1:0]         total_ext;
  logic [HX-1:0]          count_ext;

  assign cur_weight = ram_rd_data[DATA_BITS +: WEIGHT_BITS];
  assign cur_data   = ram_rd_data[DATA_BITS-1:0];
  assign ptr_inc    = CW'(ptr_r) + CW'(1);
  assign run_sum    = run_r + TW'(cur_weight);

  // width fitting between port fields and table storage
  assign in_data_ext   = DX'(in_data);
  assign in_weight_ext = WX'(in_weight);
  assign cur_data_ext  = DX'(cur_data);
  assign total_ext     = LXW'(total_r);
  assign count_ext     = HX'(count_r);
  assign sum_ext       = CMPW'(run_sum);
  assign tgt_ext       = CMPW'(target_r);

  // status to controller
  assign st.op       = op_r;
  assign st.full     = (count_r == CW'(TABLE_DEPTH));
  assign st.empty    = (count_r == '0);
  assign st.hit      = (tgt_ext <= sum_ext);
  assign st.more     = (ptr_inc < count_r);
  assign st.out_busy = out_valid_r && !out_tready;

  // RAM access steering: appends write the tail, compaction writes one below
  assign ram_wr_en   = cmd.append || cmd.move;
  assign ram_wr_addr = cmd.append ? count_r[AW-1:0] : (ptr_r - AW'(1));
  assign ram_wr_data = cmd.append ? {weight_r, data_r} : ram_rd_data;
  assign ram_rd_en   = cmd.rd_first || cmd.advance;
  assign ram_rd_addr = cmd.rd_first ? '0 : ptr_inc[AW-1:0];

  wprt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // latched word and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      data_r   <= in_data_ext[DATA_BITS-1:0];
      weight_r <= in_weight_ext[WEIGHT_BITS-1:0];
      target_r <= in_index;
      status_r <= wprt_pkg::ST_DONE;
      picked_r <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.take) begin
      picked_r <= cur_data_ext[wprt_pkg::PDATA_W-1:0];
    end
    if (cmd.rd_first) begin
      ptr_r <= '0;
      run_r <= '0;
    end
    if (cmd.advance) begin
      ptr_r <= ptr_inc[AW-1:0];
    end
    if (cmd.accum) begin
      run_r <= run_sum;
    end
  end

  // count and total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      total_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + CW'(1);
      total_r <= total_r + TW'(weight_r);
    end else begin
      if (cmd.take) begin
        total_r <= total_r - TW'(cur_weight);
      end
      if (cmd.drop) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_picked_r <= picked_r;
      out_left_r   <= total_ext[wprt_pkg::LEFT_W-1:0];
      out_held_r   <= count_ext[wprt_pkg::HELD_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_picked = out_picked_r;
  assign out_left   = out_left_r;
  assign out_held   = out_held_r;

endmodule

### hdl/weighted_pick_and_remove_table.sv
// Top level of the weighted pick-and-remove table.
//
//  channel | dir | tdata (low bit up)                           | tuser
//  in_     | in  | new_data, new_weight, pick_index, pad to 72  | operation
//  out_    | out | picked_data, weight_left, entries_held, pad  | status
//
// Append, clear and unused codes: the word is dispatched, its result is registered
// in the finish state, and the next word is taken back in idle. A pick registers its
// result after the scan and compaction: the entry RAM has one read port and is walked
// one entry a cycle, first for the weight scan, then for compaction.
// Reset clears count and total at once; entry storage needs no clearing pass.
// A finished word waits in the output register; the next word is accepted
// meanwhile and its result waits until the output register is free.
module weighted_pick_and_remove_table #(
  parameter int unsigned TABLE_DEPTH = wprt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WEIGHT_BITS = wprt_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned DATA_BITS   = wprt_pkg::DATA_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wprt_pkg::IN_TDATA_W-1:0]      in_tdata,  // new_data, new_weight, pick_index
  input  logic [wprt_pkg::OP_W-1:0]            in_tuser,  // operation
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wprt_pkg::OUT_TDATA_W-1:0]     out_tdata, // picked_data, weight_left, entries_held
  output logic [wprt_pkg::STATUS_W-1:0]        out_tuser  // status
);

  localparam int unsigned W_LO = wprt_pkg::NDATA_W;
  localparam int unsigned I_LO = W_LO + wprt_pkg::NWEIGHT_W;
  localparam int unsigned L_LO = wprt_pkg::PDATA_W;
  localparam int unsigned H_LO = L_LO + wprt_pkg::LEFT_W;
  localparam int unsigned O_USED = H_LO + wprt_pkg::HELD_W;

  wprt_pkg::cmd_t  cmd;
  wprt_pkg::stat_t st;

  logic [wprt_pkg::PDATA_W-1:0] picked;
  logic [wprt_pkg::LEFT_W-1:0]  left;
  logic [wprt_pkg::HELD_W-1:0]  held;

  wprt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  wprt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WEIGHT_BITS (WEIGHT_BITS),
    .DATA_BITS   (DATA_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_tuser),
    .in_data    (in_tdata[W_LO-1:0]),
    .in_weight  (in_tdata[I_LO-1:W_LO]),
    .in_index   (in_tdata[I_LO +: wprt_pkg::INDEX_W]),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_picked (picked),
    .out_left   (left),
    .out_held   (held)
  );

  // pack the result word, pad bits zero
  assign out_tdata = {{(wprt_pkg::OUT_TDATA_W - O_USED){1'b0}}, held, left, picked};

endmodule
